[design/mdio_mm_pkg.sv]
// shared types and command codes for the mdio management master
// no dependencies
`default_nettype none

package mdio_mm_pkg;

    localparam logic [2:0] CMD_TICK   = 3'd0;
    localparam logic [2:0] CMD_C22_RD = 3'd1;
    localparam logic [2:0] CMD_C22_WR = 3'd2;
    localparam logic [2:0] CMD_C45_RD = 3'd3;
    localparam logic [2:0] CMD_C45_WR = 3'd4;

    localparam int unsigned TAIL_BITS = 32;
    localparam int unsigned IDLE_BITS = 32;

    // classified bit-period request as it sits in the queue
    typedef struct packed {
        logic        start;
        logic        rd;
        logic        c45;
        logic [4:0]  phy;
        logic [4:0]  dev;
        logic [15:0] regaddr;
        logic [15:0] wdata;
        logic        din;
    } item_t;

    // one result item
    typedef struct packed {
        logic        rejected;
        logic [15:0] read_data;
        logic        done;
        logic        busy;
        logic        drive_enable;
        logic        drive_level;
        logic        clock_pulse;
    } res_t;

endpackage

`default_nettype wire

[design/mdio_management_master.sv]
// mdio management master (clause 22 and clause 45), one mdc bit period per request
// depends on mdio_mm_pkg, mdio_mm_front, mdio_mm_back
//
// every request on the slave channel is one mdc bit period; s_tuser carries the
// command (0 tick, 1 c22 read, 2 c22 write, 3 c45 read, 4 c45 write) and s_tdata
// the addresses, write data and the sampled mdio level. each request yields
// exactly one result on the master channel: mdc pulse, drive level and enable,
// busy, done (on m_tlast), read data and a reject flag for a start while busy.
// a c22 transaction spans PREAMBLE_BITS+64 periods, a c45 one 2*PREAMBLE_BITS+96.
// throughput is one request per cycle while m_tready is high; each request is held
// in the request queue and then in the output register before its result is offered.
// when m_tready is low the output register holds and the two-entry queue
// absorbs up to two more requests before s_tready drops.
// reset empties the queue and clears the output valid flag, the active flag and the bit position, so the
// block comes up idle with no result pending.
`default_nettype none

module mdio_management_master
#(
    parameter int unsigned PREAMBLE_BITS = 32
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // phy_address[4:0], device_or_reg_address[9:5], register_address[25:10],
    // write_data[41:26], mdio_in[42], zero fill[47:43]
    input  wire logic [47:0] s_tdata,
    // cmd[2:0]
    input  wire logic [2:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // clock_pulse[0], mdio_drive_level[1], mdio_drive_enable[2], busy_res[3],
    // read_data[19:4], rejected[20], zero fill[23:21]
    output logic [23:0]      m_tdata,
    // done_res
    output logic             m_tlast
);

    logic               q_valid;
    logic               q_ready;
    mdio_mm_pkg::item_t q_item;
    mdio_mm_pkg::res_t  res;

    mdio_mm_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item)
    );

    mdio_mm_back
    #(
        .PREAMBLE_BITS (PREAMBLE_BITS)
    )
    u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_res    (res)
    );

    assign m_tdata = {3'b000, res.rejected, res.read_data, res.busy,
                      res.drive_enable, res.drive_level, res.clock_pulse};
    assign m_tlast = res.done;

endmodule

`default_nettype wire

[design/mdio_mm_front.sv]
// front part: decodes incoming requests and holds them in a two-entry queue
// depends on mdio_mm_pkg
`default_nettype none

module mdio_mm_front
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [47:0]        s_tdata,
    input  wire logic [2:0]         s_tuser,
    output logic                    q_valid,
    input  wire logic               q_ready,
    output mdio_mm_pkg::item_t      q_item
);

    mdio_mm_pkg::item_t item_in;
    mdio_mm_pkg::item_t mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push, pop;

    always_comb
    begin
        item_in.start   = (s_tuser == mdio_mm_pkg::CMD_C22_RD)
                       || (s_tuser == mdio_mm_pkg::CMD_C22_WR)
                       || (s_tuser == mdio_mm_pkg::CMD_C45_RD)
                       || (s_tuser == mdio_mm_pkg::CMD_C45_WR);
        item_in.rd      = (s_tuser == mdio_mm_pkg::CMD_C22_RD)
                       || (s_tuser == mdio_mm_pkg::CMD_C45_RD);
        item_in.c45     = (s_tuser == mdio_mm_pkg::CMD_C45_RD)
                       || (s_tuser == mdio_mm_pkg::CMD_C45_WR);
        item_in.phy     = s_tdata[4:0];
        item_in.dev     = s_tdata[9:5];
        item_in.regaddr = s_tdata[25:10];
        item_in.wdata   = s_tdata[41:26];
        item_in.din     = s_tdata[42];
    end

    assign s_tready = (count_reg != 2'd2);
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = mem[rd_ptr_reg];
    assign push     = s_tvalid && s_tready;
    assign pop      = q_valid && q_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= item_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

[design/mdio_mm_back.sv]
// back part: frame serializer, transaction state and output register
// depends on mdio_mm_pkg
`default_nettype none

module mdio_mm_back
#(
    parameter int unsigned PREAMBLE_BITS = 32
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               q_valid,
    output logic                    q_ready,
    input  wire mdio_mm_pkg::item_t q_item,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output mdio_mm_pkg::res_t       m_res
);

    localparam int unsigned FRAME   = PREAMBLE_BITS + mdio_mm_pkg::TAIL_BITS;
    localparam int unsigned TOTAL22 = FRAME + mdio_mm_pkg::IDLE_BITS;
    localparam int unsigned TOTAL45 = 2 * FRAME + mdio_mm_pkg::IDLE_BITS;
    localparam int unsigned PW      = $clog2(TOTAL45);

    localparam logic [PW-1:0] FRAME_P   = PW'(FRAME);
    localparam logic [PW-1:0] FRAME2_P  = PW'(2 * FRAME);
    localparam logic [PW-1:0] LAST22_P  = PW'(TOTAL22 - 1);
    localparam logic [PW-1:0] LAST45_P  = PW'(TOTAL45 - 1);
    localparam logic [PW-1:0] PRE_P     = PW'(PREAMBLE_BITS);

    logic          active_reg, active_next;
    logic          rd_reg, rd_next;
    logic          c45_reg, c45_next;
    logic [PW-1:0] pos_reg, pos_next;
    logic [4:0]    phy_reg, phy_next;
    logic [4:0]    dev_reg, dev_next;
    logic [15:0]   regaddr_reg, regaddr_next;
    logic [15:0]   wdata_reg, wdata_next;
    logic [15:0]   shift_reg, shift_next;
    logic          out_valid_reg;
    mdio_mm_pkg::res_t res_reg, res_next;

    logic          begin_tx;
    logic          rd, c45;
    logic [PW-1:0] p, q, r;
    logic [4:0]    phy_c, dev_c;
    logic [15:0]   data_c, shift_c;
    logic [1:0]    st, op;
    logic          in_frame, frame_rd, last;
    logic [13:0]   hdr;
    logic [3:0]    hidx, didx;
    logic          lvl, en, smp;

    assign q_ready  = !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_res    = res_reg;

    always_comb
    begin
        begin_tx = q_item.start && !active_reg;
        rd       = begin_tx ? q_item.rd  : rd_reg;
        c45      = begin_tx ? q_item.c45 : c45_reg;
        phy_c    = begin_tx ? q_item.phy : phy_reg;
        dev_c    = begin_tx ? q_item.dev : dev_reg;
        p        = begin_tx ? '0 : pos_reg;
        shift_c  = begin_tx ? 16'd0 : shift_reg;

        // pick which frame this position belongs to
        in_frame = 1'b0;
        q        = p;
        st       = 2'b00;
        op       = 2'b00;
        data_c   = begin_tx ? q_item.wdata : wdata_reg;
        frame_rd = rd;
        if (!c45)
        begin
            in_frame = (p < FRAME_P);
            st       = 2'b01;
            op       = rd ? 2'b10 : 2'b01;
        end
        else if (p < FRAME_P)
        begin
            in_frame = 1'b1;
            data_c   = begin_tx ? q_item.regaddr : regaddr_reg;
            frame_rd = 1'b0;
        end
        else if (p < FRAME2_P)
        begin
            in_frame = 1'b1;
            q        = p - FRAME_P;
            op       = rd ? 2'b11 : 2'b01;
        end

        r    = q - PRE_P;
        hdr  = {st, op, phy_c, dev_c};
        hidx = 4'd13 - r[3:0];
        didx = 4'd15 - r[3:0];
        lvl  = 1'b1;
        en   = 1'b1;
        smp  = 1'b0;
        if (in_frame && (q >= PRE_P))
        begin
            priority if (r < PW'(14))
            begin
                lvl = hdr[hidx];
            end
            else if (frame_rd)
            begin
                // line released for turnaround and read data
                lvl = 1'b0;
                en  = 1'b0;
                smp = (r >= PW'(16));
            end
            else if (r < PW'(16))
            begin
                lvl = ~r[0];
            end
            else
            begin
                lvl = data_c[didx];
            end
        end

        if (smp)
        begin
            shift_c = {shift_c[14:0], q_item.din};
        end
        last = c45 ? (p == LAST45_P) : (p == LAST22_P);

        active_next  = active_reg;
        rd_next      = rd_reg;
        c45_next     = c45_reg;
        pos_next     = pos_reg;
        phy_next     = phy_reg;
        dev_next     = dev_reg;
        regaddr_next = regaddr_reg;
        wdata_next   = wdata_reg;
        shift_next   = shift_reg;
        if (begin_tx)
        begin
            rd_next      = q_item.rd;
            c45_next     = q_item.c45;
            phy_next     = q_item.phy;
            dev_next     = q_item.dev;
            regaddr_next = q_item.regaddr;
            wdata_next   = q_item.wdata;
        end

        res_next.rejected     = q_item.start && active_reg;
        res_next.clock_pulse  = 1'b0;
        res_next.busy         = 1'b0;
        res_next.done         = 1'b0;
        res_next.drive_level  = 1'b1;
        res_next.drive_enable = 1'b1;
        res_next.read_data    = 16'd0;
        if (active_reg || begin_tx)
        begin
            res_next.clock_pulse  = 1'b1;
            res_next.busy         = 1'b1;
            res_next.drive_level  = lvl;
            res_next.drive_enable = en;
            shift_next            = shift_c;
            if (last)
            begin
                res_next.done      = 1'b1;
                res_next.read_data = rd ? shift_c : 16'd0;
                active_next        = 1'b0;
                pos_next           = '0;
            end
            else
            begin
                active_next = 1'b1;
                pos_next    = p + PW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_valid && q_ready)
        begin
            res_reg     <= res_next;
            rd_reg      <= rd_next;
            c45_reg     <= c45_next;
            phy_reg     <= phy_next;
            dev_reg     <= dev_next;
            regaddr_reg <= regaddr_next;
            wdata_reg   <= wdata_next;
            shift_reg   <= shift_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (q_valid && q_ready)
            begin
                active_reg <= active_next;
                pos_reg    <= pos_next;
            end
            if (q_ready)
            begin
                out_valid_reg <= q_valid;
            end
        end
    end

endmodule

`default_nettype wire
